[rtl/assert_macros.svh]
// Assertion helper macros shared by the RC5 RTL.
// Needs signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/rc5_pkg.sv]
// RC5 package: word and control types, magic constants, rotate helper.
// No dependencies.
package rc5_pkg;

    localparam int WORD_W          = 32;
    localparam int ROT_W           = 5;
    localparam int KEY_WORDS       = 4;
    localparam int KEY_IDX_W       = 2;
    localparam int CFG_INDEX_W     = 8;
    localparam int ROUNDS_DEF      = 7;
    localparam int TABLE_WORDS_DEF = 26;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t MAGIC_P = 32'hb7e15163;
    localparam word_t MAGIC_Q = 32'h9e3779b9;

    // Control for the shared round unit.
    typedef struct packed {
        logic             use_xor;
        logic [ROT_W-1:0] amount;
    } unit_ctrl_t;

    // Rotate left; a count of zero leaves the word unchanged.
    function automatic word_t rotl(word_t x, logic [ROT_W-1:0] n);
        logic [2*WORD_W-1:0] d;
        begin
            d = {x, x} << n;
            return d[2*WORD_W-1:WORD_W];
        end
    endfunction

endpackage

[rtl/rc5_round_unit.sv]
// Shared RC5 arithmetic unit: (p+q+r or p^q), rotate left, add k.
// Depends on rc5_pkg.
module rc5_round_unit
    import rc5_pkg::*;
(
    input  word_t      p,
    input  word_t      q,
    input  word_t      r,
    input  word_t      k,
    input  unit_ctrl_t ctrl,
    output word_t      y
);

    word_t pre;

    always_comb
    begin
        if (ctrl.use_xor)
            pre = p ^ q;
        else
            pre = word_t'(p + q + r);
    end

    assign y = word_t'(rotl(pre, ctrl.amount) + k);

endmodule

[rtl/rc5_core.sv]
// RC5 sequencer: key expansion and encryption over one shared round unit.
// Holds the round key table and key mix words. Depends on rc5_pkg, rc5_round_unit,
// assert_macros.svh.
`include "assert_macros.svh"
module rc5_core
    import rc5_pkg::*;
#(
    parameter int ROUNDS      = ROUNDS_DEF,
    parameter int TABLE_WORDS = TABLE_WORDS_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  need_expand,
    input  word_t key_word [KEY_WORDS],
    input  word_t in_a,
    input  word_t in_b,
    output logic  idle,
    output logic  sched_done,
    output logic  res_valid,
    input  logic  res_ready,
    output word_t res_a,
    output word_t res_b
);

    localparam int IDX_W  = $clog2(TABLE_WORDS);
    localparam int STEP_W = $clog2(3 * TABLE_WORDS + 1);
    localparam int RND_W  = $clog2(ROUNDS + 1);
    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(TABLE_WORDS - 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(3 * TABLE_WORDS - 1);
    localparam logic [RND_W-1:0]  RND_LAST  = RND_W'(ROUNDS);
    localparam logic [ROT_W-1:0]  MIX_ROT   = ROT_W'(3);

    typedef enum logic [3:0] {
        IDLE, SEED, MIX_A, MIX_B, LOAD_A, LOAD_B, RND_A, RND_B, FIN
    } state_t;

    state_t                 state_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [KEY_IDX_W-1:0]   j_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [RND_W-1:0]       rnd_reg;
    logic                   sched_done_reg;

    word_t rkey_mem [TABLE_WORDS];
    word_t kmix_mem [KEY_WORDS];
    word_t seed_reg;
    word_t a_reg;
    word_t b_reg;
    word_t da_reg;
    word_t db_reg;

    word_t      rk;
    word_t      u_p;
    word_t      u_q;
    word_t      u_r;
    word_t      u_k;
    word_t      u_y;
    unit_ctrl_t u_ctrl;
    logic [IDX_W-1:0] idx_inc;

    assign rk      = rkey_mem[idx_reg];
    assign idx_inc = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;

    always_comb
    begin
        u_p            = da_reg;
        u_q            = db_reg;
        u_r            = '0;
        u_k            = rk;
        u_ctrl.use_xor = 1'b1;
        u_ctrl.amount  = db_reg[ROT_W-1:0];
        case (state_reg)
            MIX_A:
            begin
                u_p            = rk;
                u_q            = a_reg;
                u_r            = b_reg;
                u_k            = '0;
                u_ctrl.use_xor = 1'b0;
                u_ctrl.amount  = MIX_ROT;
            end
            MIX_B:
            begin
                u_p            = kmix_mem[j_reg];
                u_q            = a_reg;
                u_r            = b_reg;
                u_k            = '0;
                u_ctrl.use_xor = 1'b0;
                u_ctrl.amount  = ROT_W'(a_reg[ROT_W-1:0] + b_reg[ROT_W-1:0]);
            end
            LOAD_A:
            begin
                u_q            = '0;
                u_ctrl.use_xor = 1'b0;
                u_ctrl.amount  = '0;
            end
            LOAD_B:
            begin
                u_p            = db_reg;
                u_q            = '0;
                u_ctrl.use_xor = 1'b0;
                u_ctrl.amount  = '0;
            end
            RND_B:
            begin
                u_p           = db_reg;
                u_q           = da_reg;
                u_ctrl.amount = da_reg[ROT_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    rc5_round_unit u_unit (
        .p    (u_p),
        .q    (u_q),
        .r    (u_r),
        .k    (u_k),
        .ctrl (u_ctrl),
        .y    (u_y)
    );

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            idx_reg        <= '0;
            j_reg          <= '0;
            step_reg       <= '0;
            rnd_reg        <= '0;
            sched_done_reg <= 1'b0;
        end
        else
        begin
            sched_done_reg <= 1'b0;
            case (state_reg)
                IDLE:
                begin
                    if (start)
                    begin
                        idx_reg   <= '0;
                        j_reg     <= '0;
                        step_reg  <= '0;
                        rnd_reg   <= RND_W'(1);
                        state_reg <= need_expand ? SEED : LOAD_A;
                    end
                end
                SEED:
                begin
                    idx_reg <= idx_inc;
                    if (idx_reg == IDX_LAST)
                        state_reg <= MIX_A;
                end
                MIX_A:
                    state_reg <= MIX_B;
                MIX_B:
                begin
                    // 3*TABLE_WORDS steps leave the index back at zero
                    idx_reg  <= idx_inc;
                    j_reg    <= j_reg + 1'b1;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_LAST)
                    begin
                        sched_done_reg <= 1'b1;
                        state_reg      <= LOAD_A;
                    end
                    else
                        state_reg <= MIX_A;
                end
                LOAD_A:
                begin
                    idx_reg   <= idx_inc;
                    state_reg <= LOAD_B;
                end
                LOAD_B:
                begin
                    idx_reg   <= idx_inc;
                    state_reg <= RND_A;
                end
                RND_A:
                begin
                    idx_reg   <= idx_inc;
                    state_reg <= RND_B;
                end
                RND_B:
                begin
                    idx_reg <= idx_inc;
                    rnd_reg <= rnd_reg + 1'b1;
                    if (rnd_reg == RND_LAST)
                        state_reg <= FIN;
                    else
                        state_reg <= RND_A;
                end
                FIN:
                begin
                    if (res_ready)
                        state_reg <= IDLE;
                end
                default:
                    state_reg <= IDLE;
            endcase
        end
    end

    // Datapath and tables
    always_ff @(posedge clk)
    begin
        case (state_reg)
            IDLE:
            begin
                if (start)
                begin
                    da_reg   <= in_a;
                    db_reg   <= in_b;
                    a_reg    <= '0;
                    b_reg    <= '0;
                    seed_reg <= MAGIC_P;
                    for (int n = 0; n < KEY_WORDS; n++)
                        kmix_mem[n] <= key_word[n];
                end
            end
            SEED:
            begin
                rkey_mem[idx_reg] <= seed_reg;
                seed_reg          <= word_t'(seed_reg + MAGIC_Q);
            end
            MIX_A:
            begin
                rkey_mem[idx_reg] <= u_y;
                a_reg             <= u_y;
            end
            MIX_B:
            begin
                kmix_mem[j_reg] <= u_y;
                b_reg           <= u_y;
            end
            LOAD_A, RND_A:
                da_reg <= u_y;
            LOAD_B, RND_B:
                db_reg <= u_y;
            default:
            begin
            end
        endcase
    end

    assign idle       = (state_reg == IDLE);
    assign sched_done = sched_done_reg;
    assign res_valid  = (state_reg == FIN);
    assign res_a      = da_reg;
    assign res_b      = db_reg;

    `ASSERT_NEXT(a_start_busy, idle && start, !idle)
    `ASSERT_IMPL(a_done_after_mix, sched_done, state_reg == LOAD_A && idx_reg == '0)
    `ASSERT_NEXT(a_fin_holds, res_valid && !res_ready, res_valid && $stable(res_a))

endmodule

[rtl/rc5_block_encrypt_top.sv]
// RC5-32 block encryption top: key registers, schedule flag, output register.
// Depends on rc5_pkg and rc5_core.
//
// Usage:
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0..3 writes key
//   word 0..3 (bytes packed little-endian); any such write marks the round key table
//   stale. Other indexes are ignored. cfg_ready is always high; write only when idle.
//   Input channel (in_valid/in_ready, plain_a, plain_b): one block per item.
//   Output channel (out_valid/out_ready, cipher_a, cipher_b): one result per item.
// Sequence: after acceptance the core makes two load passes and 2*ROUNDS half-round
//   passes through the shared unit, hands the result to the output register in FIN
//   and returns to IDLE before the next accept; on the first item after a key change
//   the key expansion runs first: one seed word a cycle, then each of the
//   3*TABLE_WORDS mixing steps takes two passes through the shared round unit.
//   in_ready is low while an item is in work, so a new block is taken only once
//   the last one has been handed over.
// Reset clears the key words to zero and marks the table stale.
// If out_ready stays low, the result sits in the output register; the core
//   finishes the next item and then holds it until the register frees up.
module rc5_block_encrypt_top
    import rc5_pkg::*;
#(
    parameter int ROUNDS      = ROUNDS_DEF,
    parameter int TABLE_WORDS = TABLE_WORDS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  word_t                  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  word_t                  plain_a,
    input  word_t                  plain_b,
    output logic                   out_valid,
    input  logic                   out_ready,
    output word_t                  cipher_a,
    output word_t                  cipher_b
);

    word_t key_reg [KEY_WORDS];
    logic  sched_ready_reg;
    logic  out_valid_reg;
    word_t cipher_a_reg;
    word_t cipher_b_reg;

    logic  core_idle;
    logic  sched_done;
    logic  res_valid;
    logic  res_ready;
    word_t res_a;
    word_t res_b;
    logic  start;
    logic  key_wr;

    assign cfg_ready = 1'b1;
    assign key_wr    = cfg_valid && (cfg_index < CFG_INDEX_W'(KEY_WORDS));
    assign in_ready  = core_idle;
    assign start     = in_valid && core_idle;
    assign res_ready = !out_valid_reg || out_ready;

    rc5_core #(
        .ROUNDS      (ROUNDS),
        .TABLE_WORDS (TABLE_WORDS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .need_expand (!sched_ready_reg),
        .key_word    (key_reg),
        .in_a        (plain_a),
        .in_b        (plain_b),
        .idle        (core_idle),
        .sched_done  (sched_done),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_a       (res_a),
        .res_b       (res_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < KEY_WORDS; n++)
                key_reg[n] <= '0;
            sched_ready_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (key_wr)
            begin
                key_reg[cfg_index[KEY_IDX_W-1:0]] <= cfg_data;
                sched_ready_reg                   <= 1'b0;
            end
            else if (sched_done)
                sched_ready_reg <= 1'b1;

            if (res_valid && res_ready)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            cipher_a_reg <= res_a;
            cipher_b_reg <= res_b;
        end
    end

    assign out_valid = out_valid_reg;
    assign cipher_a  = cipher_a_reg;
    assign cipher_b  = cipher_b_reg;

endmodule
